// File: design/stepper_rate_step_scheduler_backlash_unit_macros.svh
// Assertion macros for the stepper step scheduler with backlash take-up.
// Used by the top level only; depends on a clock named clock and a reset named reset.
`ifndef STEPPER_RATE_STEP_SCHEDULER_BACKLASH_UNIT_MACROS_SVH
`define STEPPER_RATE_STEP_SCHEDULER_BACKLASH_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SRSB_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define SRSB_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/srsb_pkg.sv
// Package for the stepper step scheduler with backlash take-up.
// Holds widths, constants, register indexes and the sequencer state type.
`default_nettype none

package srsb_pkg;

   // Field widths
   localparam int TimeW   = 48;
   localparam int RateW   = 32;
   localparam int SumW    = 34;
   localparam int MagW    = 33;
   localparam int CfgW    = 16;
   localparam int CsrIdxW = 2;

   // Interval divider: dividend width and iteration counter width
   localparam int QuoW   = 28;
   localparam int CntW   = 5;

   // Rate threshold (0.1 step/s in 1/256 step/s), floor on the step interval
   localparam int RateMin       = 26;
   localparam int MinInterval   = 50;
   localparam int TakeupDefault = 200;

   // Dividends: 1e6 us times 256 for the commanded rate, 1e6 us for take-up
   localparam logic [QuoW-1:0] RateDividend   = 28'd256000000;
   localparam logic [QuoW-1:0] TakeupDividend = 28'd1000000;

   // Operations
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_LOAD = 1'b1;

   // Configuration register indexes
   localparam logic [CsrIdxW-1:0] CSR_BACKLASH_STEPS = 2'd0;
   localparam logic [CsrIdxW-1:0] CSR_TAKEUP_RATE    = 2'd1;
   localparam logic [CsrIdxW-1:0] CSR_TRACKING_EN    = 2'd2;
   localparam logic [CsrIdxW-1:0] CSR_INVERT_DIR     = 2'd3;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_PLAN = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_DONE = 5'b10000
   } srsb_state_type;

endpackage

`default_nettype wire

// File: design/stepper_rate_step_scheduler_backlash_unit.sv
// Stepper step scheduler with backlash take-up: top level and only module.
// Depends on srsb_pkg and stepper_rate_step_scheduler_backlash_unit_macros.svh.
//
// Usage:
//  - Request channel (req_*): op 0 is a time tick carrying now_us and three
//    signed rate terms; op 1 loads the step counter from position_value.
//    A request is taken when req_valid is high and req_stall is low.
//  - Response channel (rsp_*): one response per request, held in an output
//    register until taken (rsp_valid high, rsp_stall low).
//  - Configuration (csr_*): always ready; write only while no request is open.
//  - Sequence: a load passes through SUM to DONE; a tick that does not step
//    passes through SUM, PLAN and DONE; a tick that steps also passes DIV,
//    where the 28 iterations of the shared restoring divider compute
//    the step interval one quotient bit per cycle.
//  - Throughput: one request at a time; req_stall stays high from acceptance
//    until the response is written into the output register, so the next
//    request can be taken while that response still waits.
//  - A stalled response holds the sequencer in DONE until the output register frees.
//  - Reset (synchronous, active high) clears the step counter, the schedule,
//    take-up state and the registers (take-up rate returns to 200 steps/s).
`default_nettype none
`include "stepper_rate_step_scheduler_backlash_unit_macros.svh"

module stepper_rate_step_scheduler_backlash_unit (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel
   input  wire logic                                req_valid,
   output      logic                                req_stall,
   input  wire logic                                req_op,
   input  wire logic [srsb_pkg::TimeW-1:0]          req_now_us,
   input  wire logic signed [srsb_pkg::RateW-1:0]   req_user_rate,
   input  wire logic signed [srsb_pkg::RateW-1:0]   req_goto_rate,
   input  wire logic signed [srsb_pkg::RateW-1:0]   req_tracking_rate,
   input  wire logic signed [srsb_pkg::TimeW-1:0]   req_position_value,
   // Response channel
   output      logic                                rsp_valid,
   input  wire logic                                rsp_stall,
   output      logic                                rsp_step_pulse,
   output      logic                                rsp_dir_level,
   output      logic                                rsp_idle,
   output      logic [srsb_pkg::TimeW-1:0]          rsp_next_due_us,
   output      logic signed [srsb_pkg::TimeW-1:0]   rsp_position,
   output      logic                                rsp_takeup_active,
   // Configuration write channel
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [srsb_pkg::CsrIdxW-1:0]        csr_index,
   input  wire logic [srsb_pkg::CfgW-1:0]           csr_wdata
);
   import srsb_pkg::*;

   // Configuration registers
   logic [CfgW-1:0] backlash_ff;
   logic [CfgW-1:0] takeup_rate_ff;
   logic            track_en_ff;
   logic            invert_ff;

   // Sequencer
   srsb_state_type  state_ff, state_in;

   // Captured request
   logic                    op_ff;
   logic [TimeW-1:0]        now_ff;
   logic signed [RateW-1:0] user_ff, goto_ff, track_ff;
   logic [TimeW-1:0]        pos_ff;

   // Per-request plan
   logic signed [SumW-1:0]  sum_ff, sum_in;
   logic                    move_ff, move_in;
   logic                    tk_now_ff, tk_now_in;
   logic                    neg_ff, neg_in;
   logic                    hit_ff, hit_in;

   // Shared divider
   logic [MagW-1:0]         rem_ff, rem_in;
   logic [QuoW-1:0]         quo_ff, quo_in;
   logic [MagW-1:0]         dvs_ff, dvs_in;
   logic [CntW-1:0]         cnt_ff, cnt_in;

   // Axis state
   logic [TimeW-1:0]        step_count_ff, step_count_in;
   logic                    last_neg_ff, last_neg_in;
   logic                    cmd_valid_ff, cmd_valid_in;
   logic                    cmd_neg_ff, cmd_neg_in;
   logic [CfgW-1:0]         tk_left_ff, tk_left_in;
   logic                    tk_on_ff, tk_on_in;
   logic                    tk_neg_ff, tk_neg_in;
   logic [TimeW-1:0]        due_ff, due_in;
   logic                    dir_pin_ff, dir_pin_in;

   // Output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    pulse_ff, pulse_in;
   logic                    dir_out_ff, dir_out_in;
   logic                    idle_ff, idle_in;
   logic [TimeW-1:0]        due_out_ff, due_out_in;
   logic [TimeW-1:0]        pos_out_ff, pos_out_in;
   logic                    tk_out_ff, tk_out_in;

   // Datapath intermediates
   logic                    req_take;
   logic                    out_free;
   logic [SumW-1:0]         neg_sum;
   logic [MagW-1:0]         mag;
   logic                    rate_ok;
   logic                    sum_neg;
   logic                    cmd_change;
   logic [TimeW-1:0]        due_sel;
   logic [SumW-1:0]         trial;
   logic [SumW-1:0]         diff;
   logic                    trial_ge;
   logic [QuoW-1:0]         interval;
   logic [CfgW-1:0]         tk_left_dec;

   assign req_take  = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;

   // Magnitude and direction of the summed rate
   assign sum_neg = sum_ff[SumW-1];
   assign neg_sum = ~sum_ff + SumW'(1);
   assign mag     = sum_neg ? neg_sum[MagW-1:0] : sum_ff[MagW-1:0];
   assign rate_ok = (mag >= MagW'(RateMin));
   assign cmd_change = rate_ok && (!cmd_valid_ff || (cmd_neg_ff != sum_neg));
   assign due_sel = (due_ff != '0) ? due_ff : now_ff;

   // Divider step: shift in one dividend bit, subtract when it fits
   assign trial    = {rem_ff, quo_ff[QuoW-1]};
   assign diff     = trial - {1'b0, dvs_ff};
   assign trial_ge = (trial >= {1'b0, dvs_ff});

   // Clamp the interval and count down take-up
   assign interval    = (quo_ff < QuoW'(MinInterval)) ? QuoW'(MinInterval) : quo_ff;
   assign tk_left_dec = tk_left_ff - CfgW'(1);

   // Next-state logic of the sequencer and datapath
   always_comb begin
      state_in      = state_ff;
      sum_in        = sum_ff;
      move_in       = move_ff;
      tk_now_in     = tk_now_ff;
      neg_in        = neg_ff;
      hit_in        = hit_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      dvs_in        = dvs_ff;
      cnt_in        = cnt_ff;
      step_count_in = step_count_ff;
      last_neg_in   = last_neg_ff;
      cmd_valid_in  = cmd_valid_ff;
      cmd_neg_in    = cmd_neg_ff;
      tk_left_in    = tk_left_ff;
      tk_on_in      = tk_on_ff;
      tk_neg_in     = tk_neg_ff;
      due_in        = due_ff;
      dir_pin_in    = dir_pin_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      pulse_in      = pulse_ff;
      dir_out_in    = dir_out_ff;
      idle_in       = idle_ff;
      due_out_in    = due_out_ff;
      pos_out_in    = pos_out_ff;
      tk_out_in     = tk_out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Add the rate terms; loads skip straight to the update
            sum_in = SumW'(user_ff) + SumW'(goto_ff) +
                     (track_en_ff ? SumW'(track_ff) : SumW'(0));
            state_in = (op_ff == OP_LOAD) ? ST_DONE : ST_PLAN;
         end
         ST_PLAN: begin
            // Track direction changes and arm take-up on a reversal
            if (cmd_change) begin
               cmd_valid_in = 1'b1;
               cmd_neg_in   = sum_neg;
               if ((last_neg_ff != sum_neg) && (backlash_ff != '0)) begin
                  tk_left_in = backlash_ff;
                  tk_on_in   = 1'b1;
                  tk_neg_in  = sum_neg;
               end else begin
                  tk_left_in = '0;
                  tk_on_in   = 1'b0;
               end
            end
            tk_now_in = tk_on_in && (tk_left_in != '0);
            neg_in    = tk_now_in ? tk_neg_in : sum_neg;
            move_in   = tk_now_in || rate_ok;
            hit_in    = ({1'b0, now_ff} + (TimeW+1)'(1)) >= {1'b0, due_sel};
            // Load the divider
            rem_in = '0;
            quo_in = tk_now_in ? TakeupDividend : RateDividend;
            dvs_in = tk_now_in ? MagW'(takeup_rate_ff) : mag;
            cnt_in = CntW'(QuoW - 1);
            state_in = (move_in && hit_in) ? ST_DIV : ST_DONE;
         end
         ST_DIV: begin
            // One quotient bit per cycle
            rem_in = trial_ge ? diff[MagW-1:0] : trial[MagW-1:0];
            quo_in = {quo_ff[QuoW-2:0], trial_ge};
            cnt_in = cnt_ff - CntW'(1);
            if (cnt_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               pulse_in = 1'b0;
               idle_in  = 1'b0;
               if (op_ff == OP_LOAD) begin
                  // Load the counter and cancel take-up
                  step_count_in = pos_ff;
                  tk_left_in    = '0;
                  tk_on_in      = 1'b0;
                  idle_in       = (due_ff == '0);
               end else if (!move_ff) begin
                  // Stop: clear the schedule
                  due_in  = '0;
                  idle_in = 1'b1;
               end else if (hit_ff) begin
                  // Issue a step and schedule the next one
                  if (!tk_now_ff) begin
                     step_count_in = neg_ff ? (step_count_ff - TimeW'(1))
                                            : (step_count_ff + TimeW'(1));
                     last_neg_in   = neg_ff;
                  end else begin
                     tk_left_in = tk_left_dec;
                     if (tk_left_dec == '0) begin
                        tk_on_in    = 1'b0;
                        last_neg_in = neg_ff;
                     end
                  end
                  due_in     = now_ff + TimeW'(interval);
                  dir_pin_in = (!neg_ff) ^ invert_ff;
                  pulse_in   = 1'b1;
               end
               rsp_valid_in = 1'b1;
               dir_out_in   = dir_pin_in;
               due_out_in   = due_in;
               pos_out_in   = step_count_in;
               tk_out_in    = tk_on_in && (tk_left_in != '0);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer, axis state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_count_ff <= '0;
         last_neg_ff   <= 1'b0;
         cmd_valid_ff  <= 1'b0;
         cmd_neg_ff    <= 1'b0;
         tk_left_ff    <= '0;
         tk_on_ff      <= 1'b0;
         tk_neg_ff     <= 1'b0;
         due_ff        <= '0;
         dir_pin_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_count_ff <= step_count_in;
         last_neg_ff   <= last_neg_in;
         cmd_valid_ff  <= cmd_valid_in;
         cmd_neg_ff    <= cmd_neg_in;
         tk_left_ff    <= tk_left_in;
         tk_on_ff      <= tk_on_in;
         tk_neg_ff     <= tk_neg_in;
         due_ff        <= due_in;
         dir_pin_ff    <= dir_pin_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Capture the request, hold the datapath and the response payload
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_op;
         now_ff   <= req_now_us;
         user_ff  <= req_user_rate;
         goto_ff  <= req_goto_rate;
         track_ff <= req_tracking_rate;
         pos_ff   <= req_position_value;
      end
      sum_ff     <= sum_in;
      move_ff    <= move_in;
      tk_now_ff  <= tk_now_in;
      neg_ff     <= neg_in;
      hit_ff     <= hit_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      dvs_ff     <= dvs_in;
      cnt_ff     <= cnt_in;
      pulse_ff   <= pulse_in;
      dir_out_ff <= dir_out_in;
      idle_ff    <= idle_in;
      due_out_ff <= due_out_in;
      pos_out_ff <= pos_out_in;
      tk_out_ff  <= tk_out_in;
   end

   // Configuration registers; a zero take-up rate stores the default
   always_ff @(posedge clock) begin
      if (reset) begin
         backlash_ff    <= '0;
         takeup_rate_ff <= CfgW'(TakeupDefault);
         track_en_ff    <= 1'b0;
         invert_ff      <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BACKLASH_STEPS: backlash_ff <= csr_wdata;
            CSR_TAKEUP_RATE: begin
               takeup_rate_ff <= (csr_wdata == '0) ? CfgW'(TakeupDefault) : csr_wdata;
            end
            CSR_TRACKING_EN: track_en_ff <= csr_wdata[0];
            CSR_INVERT_DIR:  invert_ff   <= csr_wdata[0];
            default: begin
               backlash_ff <= backlash_ff;
            end
         endcase
      end
   end

   // Drive the response ports
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_step_pulse    = pulse_ff;
   assign rsp_dir_level     = dir_out_ff;
   assign rsp_idle          = idle_ff;
   assign rsp_next_due_us   = due_out_ff;
   assign rsp_position      = pos_out_ff;
   assign rsp_takeup_active = tk_out_ff;

   // Checks
   `SRSB_ASSERT_NEXT(a_div_ends, (state_ff == ST_DIV) && (cnt_ff == '0),
      state_ff == ST_DONE, "divider did not finish after its last iteration")
   `SRSB_ASSERT_NOW(a_takeup_count, tk_on_ff, tk_left_ff != '0,
      "take-up active with no steps left")
   `SRSB_ASSERT_NEXT(a_stop_clears,
      (state_ff == ST_DONE) && out_free && (op_ff == OP_TICK) && !move_ff,
      (due_ff == '0) && rsp_idle, "stopped axis kept a schedule")
   `SRSB_ASSERT_NOW(a_busy_stall, state_ff != ST_IDLE, req_stall, "request taken while busy")

endmodule

`default_nettype wire

// File: dv/tb_stepper_rate_step_scheduler_backlash_unit.sv
// Self-checking testbench for the stepper step scheduler with backlash take-up.
// Drives ticks, loads and register writes; checks every response against an
// in-bench scheduler model or a written expectation. Depends on srsb_pkg and the top level only.
`timescale 1ns / 100ps

module tb_stepper_rate_step_scheduler_backlash_unit;
   import srsb_pkg::*;

   typedef struct packed {
      logic                    op;
      logic [TimeW-1:0]        now_us;
      int                      user_rate;
      int                      goto_rate;
      int                      tracking_rate;
      logic signed [TimeW-1:0] position_value;
   } step_req_t;

   typedef struct packed {
      logic                    step_pulse;
      logic                    dir_level;
      logic                    idle;
      logic [TimeW-1:0]        next_due_us;
      logic signed [TimeW-1:0] position;
      logic                    takeup_active;
   } step_rsp_t;

   typedef enum {ROW_REQ, ROW_CSR} row_kind_e;

   typedef struct {
      row_kind_e          kind;
      step_req_t          req;
      logic [CsrIdxW-1:0] csr_idx;
      logic [CfgW-1:0]    csr_val;
      bit                 typed;
      step_rsp_t          want;
   } stim_row_t;

   localparam step_rsp_t NO_WANT = '0;
   localparam logic [TimeW-1:0] POS_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [TimeW-1:0] POS_MIN = 48'h8000_0000_0000;
   localparam int PHASES = 7;
   localparam int ITEMS_PER_PHASE = 100;
   localparam int LONG_HOLD = 400;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_op = OP_TICK;
   logic [TimeW-1:0] req_now_us = '0;
   logic signed [RateW-1:0] req_user_rate = '0;
   logic signed [RateW-1:0] req_goto_rate = '0;
   logic signed [RateW-1:0] req_tracking_rate = '0;
   logic signed [TimeW-1:0] req_position_value = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_step_pulse;
   logic rsp_dir_level;
   logic rsp_idle;
   logic [TimeW-1:0] rsp_next_due_us;
   logic signed [TimeW-1:0] rsp_position;
   logic rsp_takeup_active;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CsrIdxW-1:0] csr_index = '0;
   logic [CfgW-1:0] csr_wdata = '0;

   stepper_rate_step_scheduler_backlash_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_now_us         (req_now_us),
      .req_user_rate      (req_user_rate),
      .req_goto_rate      (req_goto_rate),
      .req_tracking_rate  (req_tracking_rate),
      .req_position_value (req_position_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_step_pulse     (rsp_step_pulse),
      .rsp_dir_level      (rsp_dir_level),
      .rsp_idle           (rsp_idle),
      .rsp_next_due_us    (rsp_next_due_us),
      .rsp_position       (rsp_position),
      .rsp_takeup_active  (rsp_takeup_active),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scheduler model state and register copies
   logic [TimeW-1:0] pos_count;
   int               prev_dir;
   int               cmd_dir;
   logic [CfgW-1:0]  takeup_left;
   bit               takeup_on;
   int               takeup_dir;
   logic [TimeW-1:0] due_at;
   logic             pin_level;
   logic [CfgW-1:0]  cfg_backlash;
   logic [CfgW-1:0]  cfg_takeup_rate;
   logic             cfg_track_en;
   logic             cfg_invert;

   step_rsp_t pending_rsps[$];
   stim_row_t directed_rows[$];
   step_rsp_t oldest;
   int mismatch_count = 0;
   int rsp_checked = 0;
   int req_cnt = 0;
   int load_cnt = 0;
   int pulse_cnt = 0;
   int takeup_cnt = 0;
   int settings_cnt = 1;
   longint unsigned time_cursor = 0;
   longint seg_sum = 256;

   function automatic void reset_model();
      pos_count = '0;
      prev_dir = 1;
      cmd_dir = 0;
      takeup_left = '0;
      takeup_on = 1'b0;
      takeup_dir = 0;
      due_at = '0;
      pin_level = 1'b0;
      cfg_backlash = '0;
      cfg_takeup_rate = CfgW'(TakeupDefault);
      cfg_track_en = 1'b0;
      cfg_invert = 1'b0;
   endfunction

   function automatic void apply_csr(logic [CsrIdxW-1:0] idx, logic [CfgW-1:0] val);
      case (idx)
         CSR_BACKLASH_STEPS: cfg_backlash = val;
         // zero falls back to the default take-up rate
         CSR_TAKEUP_RATE: cfg_takeup_rate = (val == 0) ? CfgW'(TakeupDefault) : val;
         CSR_TRACKING_EN: cfg_track_en = val[0];
         CSR_INVERT_DIR: cfg_invert = val[0];
         default: ;
      endcase
   endfunction

   // Advance the scheduler by one request and return the response it gives
   function automatic step_rsp_t schedule_step(step_req_t r);
      step_rsp_t res;
      longint sum;
      longint unsigned mag;
      longint unsigned interval;
      longint unsigned now;
      longint unsigned due;
      longint unsigned nxt;
      int dir;
      bit takeup;
      res = '0;
      if (r.op == OP_LOAD) begin
         pos_count = r.position_value;
         takeup_left = '0;
         takeup_on = 1'b0;
         res.idle = (due_at == 0);
      end else begin
         now = r.now_us;
         sum = longint'(r.user_rate) + longint'(r.goto_rate);
         if (cfg_track_en) sum += longint'(r.tracking_rate);
         mag = (sum < 0) ? -sum : sum;
         dir = 0;
         interval = 0;
         if (mag >= RateMin) begin
            dir = (sum >= 0) ? 1 : -1;
            interval = 64'(RateDividend) / mag;
         end
         // arm or cancel take-up on a change of commanded direction
         if (dir != 0 && cmd_dir != dir) begin
            cmd_dir = dir;
            if (prev_dir != 0 && prev_dir != dir && cfg_backlash > 0) begin
               takeup_left = cfg_backlash;
               takeup_on = 1'b1;
               takeup_dir = dir;
            end else begin
               takeup_left = '0;
               takeup_on = 1'b0;
            end
         end
         takeup = takeup_on && takeup_left > 0;
         if (takeup) begin
            dir = takeup_dir;
            interval = 64'(TakeupDividend) / 64'(cfg_takeup_rate);
         end
         if (!takeup && dir == 0) begin
            due_at = '0;
            res.idle = 1'b1;
         end else begin
            due = (due_at != 0) ? due_at : now;
            if (now + 1 >= due) begin
               if (interval < MinInterval) interval = MinInterval;
               if (!takeup) begin
                  if (dir > 0) pos_count = pos_count + 1'b1;
                  else pos_count = pos_count - 1'b1;
                  prev_dir = dir;
               end else begin
                  takeup_left = takeup_left - 1'b1;
                  if (takeup_left == 0) begin
                     takeup_on = 1'b0;
                     prev_dir = dir;
                  end
               end
               nxt = now + interval;
               due_at = nxt[TimeW-1:0];
               pin_level = (dir > 0) != cfg_invert;
               res.step_pulse = 1'b1;
            end
         end
      end
      res.dir_level = pin_level;
      res.next_due_us = due_at;
      res.position = pos_count;
      res.takeup_active = takeup_on && takeup_left > 0;
      return res;
   endfunction

   task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatch_count < 100)
         $display("[%0t] MISMATCH %s: got %0h, expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // Compare each taken response with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsps.size() == 0) begin
            flag_mismatch("response with nothing expected", 64'd1, 64'd0);
         end else begin
            oldest = pending_rsps.pop_front();
            rsp_checked++;
            if (rsp_step_pulse !== oldest.step_pulse)
               flag_mismatch("step_pulse", rsp_step_pulse, oldest.step_pulse);
            if (rsp_dir_level !== oldest.dir_level)
               flag_mismatch("dir_level", rsp_dir_level, oldest.dir_level);
            if (rsp_idle !== oldest.idle)
               flag_mismatch("idle", rsp_idle, oldest.idle);
            if (rsp_next_due_us !== oldest.next_due_us)
               flag_mismatch("next_due_us", rsp_next_due_us, oldest.next_due_us);
            if (rsp_position !== oldest.position)
               flag_mismatch("position", rsp_position, oldest.position);
            if (rsp_takeup_active !== oldest.takeup_active)
               flag_mismatch("takeup_active", rsp_takeup_active, oldest.takeup_active);
         end
      end
   end

   // Stall the response side in varying patterns, with one long hold
   initial begin : rsp_stall_pattern
      int mode;
      int len;
      int period;
      int cyc;
      bit held;
      held = 1'b0;
      cyc = 0;
      forever begin
         if (!held && rsp_checked >= 150) begin
            held = 1'b1;
            repeat (LONG_HOLD) @(negedge clock) rsp_stall = 1'b1;
         end else begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(10, 60);
            period = $urandom_range(2, 5);
            repeat (len) begin
               @(negedge clock);
               cyc++;
               case (mode)
                  0: rsp_stall = 1'b0;
                  1: rsp_stall = ($urandom_range(0, 99) < 35);
                  default: rsp_stall = (cyc % period) == 0;
               endcase
            end
         end
      end
   end

   // Offer one request, hold it until taken, then record what it should give
   task automatic send_req(step_req_t r, bit typed, step_rsp_t want);
      step_rsp_t pred;
      @(negedge clock);
      req_valid = 1'b1;
      req_op = r.op;
      req_now_us = r.now_us;
      req_user_rate = r.user_rate;
      req_goto_rate = r.goto_rate;
      req_tracking_rate = r.tracking_rate;
      req_position_value = r.position_value;
      do @(posedge clock); while (req_stall);
      pred = schedule_step(r);
      pending_rsps.push_back(typed ? want : pred);
      req_cnt++;
      if (r.op == OP_LOAD) load_cnt++;
      if (pred.step_pulse) pulse_cnt++;
      if (pred.takeup_active) takeup_cnt++;
   endtask

   task automatic idle_gap(int n);
      if (n > 0) begin
         @(negedge clock) req_valid = 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   // Drop valid and wait until every open request has answered
   task automatic wait_drained();
      @(negedge clock) req_valid = 1'b0;
      while (pending_rsps.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxW-1:0] idx, logic [CfgW-1:0] val);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      do @(posedge clock); while (!csr_ready);
      apply_csr(idx, val);
      @(negedge clock) csr_valid = 1'b0;
   endtask

   function automatic void add_req(logic op, logic [TimeW-1:0] now, int u, int g, int t,
                                   logic [TimeW-1:0] pos, bit typed, step_rsp_t want);
      stim_row_t row;
      row.kind = ROW_REQ;
      row.req = step_req_t'{op, now, u, g, t, pos};
      row.csr_idx = '0;
      row.csr_val = '0;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endfunction

   function automatic void add_csr(logic [CsrIdxW-1:0] idx, logic [CfgW-1:0] val);
      stim_row_t row;
      row.kind = ROW_CSR;
      row.req = '0;
      row.csr_idx = idx;
      row.csr_val = val;
      row.typed = 1'b0;
      row.want = NO_WANT;
      directed_rows.push_back(row);
   endfunction

   // Directed table: extremes, both operations, wraps and take-up
   function automatic void build_directed();
      // idle after reset, load and threshold edges
      add_req(OP_TICK, 0, 0, 0, 0, 0, 1, step_rsp_t'{1'b0, 1'b0, 1'b1, 48'd0, 48'd0, 1'b0});
      add_req(OP_LOAD, 0, 0, 0, 0, POS_MAX, 1,
              step_rsp_t'{1'b0, 1'b0, 1'b1, 48'd0, POS_MAX, 1'b0});
      add_req(OP_TICK, 100, 25, 0, 0, 0, 1,
              step_rsp_t'{1'b0, 1'b0, 1'b1, 48'd0, POS_MAX, 1'b0});
      // slowest rate steps at once and wraps the counter upward
      add_req(OP_TICK, 200, 26, 0, 0, 0, 1,
              step_rsp_t'{1'b1, 1'b1, 1'b0, 48'd9846353, POS_MIN, 1'b0});
      // not yet due, then just due: direction pin holds, tracking ignored
      add_req(OP_TICK, 300, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, NO_WANT);
      add_req(OP_TICK, 9846352, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, NO_WANT);
      // reversal without backlash, counter wraps downward
      add_req(OP_LOAD, 9846400, 0, 0, 0, POS_MIN, 0, NO_WANT);
      add_req(OP_TICK, 9846402, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, NO_WANT);
      // zero take-up rate falls back to default; widest backlash
      add_csr(CSR_TAKEUP_RATE, 16'd0);
      add_csr(CSR_BACKLASH_STEPS, 16'hFFFF);
      add_req(OP_TICK, 9846500, 1000, 0, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 9851500, 0, 1000, 0, 0, 0, NO_WANT);
      // load cancels take-up
      add_req(OP_LOAD, 9851600, 0, 0, 0, 0, 0, NO_WANT);
      add_csr(CSR_INVERT_DIR, 16'hFFFF);
      add_csr(CSR_TRACKING_EN, 16'h0001);
      add_csr(CSR_TAKEUP_RATE, 16'hFFFF);
      add_csr(CSR_BACKLASH_STEPS, 16'd2);
      // tracking alone drives the axis, then a short take-up
      add_req(OP_TICK, 9860000, 0, 0, -5000, 0, 0, NO_WANT);
      add_req(OP_TICK, 9870000, 5000, 0, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 9870050, 5000, 0, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 9870100, 0, 5000, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 9870200, 0, 0, 5000, 0, 0, NO_WANT);
      // most negative sum of three terms
      add_req(OP_TICK, 9880000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, NO_WANT);
      // due time wraps to zero, then past zero, near the end of time
      add_req(OP_TICK, 48'hFFFF_FFFF_FF9C, 2560000, 0, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 48'hFFFF_FFFF_FFFF, 0, 2560000, 0, 0, 0, NO_WANT);
      add_req(OP_TICK, 0, 0, 0, 0, 0, 0, NO_WANT);
   endfunction

   // Random request: mostly steady segments with reversals, some loads and noise
   function automatic step_req_t make_random_req();
      step_req_t r;
      int unsigned roll;
      longint unsigned nxt;
      longint m;
      longint s;
      longint a;
      longint t;
      bit shaped;
      roll = $urandom_range(0, 99);
      r.op = OP_TICK;
      r.user_rate = $urandom;
      r.goto_rate = $urandom;
      r.tracking_rate = $urandom;
      r.position_value = {16'($urandom), 32'($urandom)};
      // jump to the due time most of the time, else creep forward
      if (due_at != 0 && $urandom_range(0, 99) < 70)
         nxt = longint'(due_at) - 1 + $urandom_range(0, 3);
      else
         nxt = time_cursor + $urandom_range(0, 300);
      if (nxt < time_cursor) nxt = time_cursor;
      time_cursor = nxt;
      r.now_us = nxt[TimeW-1:0];
      shaped = 1'b0;
      s = 0;
      if (roll < 8) begin
         r.op = OP_LOAD;
      end else if (roll < 16) begin
         shaped = 1'b0;
      end else if (roll < 24) begin
         s = longint'($urandom_range(0, 50)) - 25;
         shaped = 1'b1;
      end else begin
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            case ($urandom_range(0, 2))
               0: m = $urandom_range(26, 400);
               1: m = $urandom_range(400, 2560000);
               default: m = $urandom_range(2560000, 32'h2000_0000);
            endcase
            seg_sum = $urandom_range(0, 1) ? m : -m;
         end else if (roll < 20) begin
            seg_sum = -seg_sum;
         end
         s = seg_sum;
         shaped = 1'b1;
      end
      // split the wanted sum over the rate terms
      if (shaped) begin
         a = longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000;
         t = cfg_track_en ? longint'($urandom_range(0, 32'h3FFF_FFFF)) - 64'sh2000_0000 : 0;
         r.user_rate = int'(a);
         if (cfg_track_en) r.tracking_rate = int'(t);
         r.goto_rate = int'(s - a - t);
      end
      return r;
   endfunction

   initial begin : stimulus
      int ph;
      int k;
      int burst_left;
      int cyc;
      int directed_cnt;
      logic [CfgW-1:0] bl;
      logic [CfgW-1:0] tr;
      logic te;
      logic inv;
      repeat (3) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      reset_model();
      build_directed();

      // walk the directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            wait_drained();
            write_csr(directed_rows[i].csr_idx, directed_rows[i].csr_val);
         end else begin
            send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
            idle_gap($urandom_range(0, 2));
         end
      end
      directed_cnt = req_cnt;

      // random phases, each under its own register setting
      time_cursor = 1000;
      burst_left = 0;
      for (ph = 0; ph < PHASES; ph++) begin
         wait_drained();
         case (ph)
            0: begin bl = 3; tr = 0; te = 1'b1; inv = 1'b0; end
            1: begin bl = 0; tr = 16'hFFFF; te = 1'b0; inv = 1'b1; end
            2: begin bl = 1; tr = 1; te = 1'b1; inv = 1'b1; end
            3: begin bl = 16'hFFFF; tr = 16'hFFFF; te = 1'b0; inv = 1'b0; end
            default: begin
               bl = $urandom_range(1, 6);
               tr = $urandom_range(0, 5000);
               te = $urandom_range(0, 1);
               inv = $urandom_range(0, 1);
            end
         endcase
         write_csr(CSR_BACKLASH_STEPS, bl);
         write_csr(CSR_TAKEUP_RATE, tr);
         write_csr(CSR_TRACKING_EN, {15'($urandom), te});
         write_csr(CSR_INVERT_DIR, {15'($urandom), inv});
         settings_cnt++;
         for (k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (burst_left == 0) begin
               idle_gap($urandom_range(0, 1) ? 0 : $urandom_range(1, 8));
               burst_left = $urandom_range(1, 16);
            end
            // let the block run dry once in mid phase
            if (ph == 2 && k == ITEMS_PER_PHASE / 2) wait_drained();
            send_req(make_random_req(), 1'b0, NO_WANT);
            burst_left--;
         end
      end

      // drain, then allow the block's latency to pass
      @(negedge clock) req_valid = 1'b0;
      cyc = 0;
      while (pending_rsps.size() != 0 && cyc < 50000) begin
         @(posedge clock);
         cyc++;
      end
      repeat (40) @(posedge clock);
      if (pending_rsps.size() != 0)
         flag_mismatch("expectations left over", pending_rsps.size(), 64'd0);
      $display("Covered %0d requests (%0d directed, %0d loads) under %0d register settings.",
               req_cnt, directed_cnt, load_cnt, settings_cnt);
      $display("Checked %0d responses: %0d step pulses, %0d with take-up pending.",
               rsp_checked, pulse_cnt, takeup_cnt);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // End a hung run
   initial begin : watchdog
      #10_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: files.f
+incdir+design
design/srsb_pkg.sv
design/stepper_rate_step_scheduler_backlash_unit.sv
dv/tb_stepper_rate_step_scheduler_backlash_unit.sv
